// ----- sv/sdcp_pkg.sv -----
// Package for the serial DAC command parser: character codes, parse phase,
// command kind and line status types, default parameter values.
// No dependencies.
package sdcp_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int DAC_BITS_DEF   = 12;
    localparam int DAC_WORD_W     = 24;
    localparam int VALUE_W        = 16;

    localparam logic [7:0] CH_CMD_SET   = 8'h61;  // 'a'
    localparam logic [7:0] CH_CMD_STORE = 8'h62;  // 'b'
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    // Parse phase of the current line, one-hot.
    typedef enum logic [4:0] {
        PH_CMD  = 5'b00001,
        PH_SKIP = 5'b00010,
        PH_A    = 5'b00100,
        PH_B    = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_STORE = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_COLLECT = 3'd0,
        ST_DAC     = 3'd1,
        ST_FMT_ERR = 3'd2,
        ST_STORE   = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    // v * 10 + d, wrapping at 16 bits
    function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] v,
                                                     input logic [3:0]         d);
        add_digit = (v << 3) + (v << 1) + VALUE_W'(d);
    endfunction

endpackage

// ----- sv/serial_dac_command_parser.sv -----
// Serial DAC command parser top level: line buffer count, streaming parser
// for 'a' (set) and 'b' (store) commands, registered result beat.
// Depends on sdcp_pkg.
//
//  channel | signals                          | beat carries
//  --------+----------------------------------+----------------------------------
//  in      | in_valid / in_ready              | rx_char
//  out     | out_valid / out_ready            | echo_valid, echo_char, line_done,
//          |                                  | status, value_a, value_b, dac_word
//
// One beat in gives one beat out. The input beat is registered, parsed
// against the line state, and the result lands in the output register;
// one beat per cycle is sustained while out_ready stays high.
// Reset clears the line state, both channel values and both stage valids.
// A stalled output holds the input stage; in_ready drops only when both
// stages are full and out_ready is low.
module serial_dac_command_parser #(
    parameter int LINE_BYTES = sdcp_pkg::LINE_BYTES_DEF,
    parameter int DAC_BITS   = sdcp_pkg::DAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_char,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             echo_valid,
    output logic [7:0]                       echo_char,
    output logic                             line_done,
    output logic [2:0]                       status,
    output logic [sdcp_pkg::VALUE_W-1:0]     value_a,
    output logic [sdcp_pkg::VALUE_W-1:0]     value_b,
    output logic [sdcp_pkg::DAC_WORD_W-1:0]  dac_word
);
    import sdcp_pkg::*;

    localparam int CNT_W = $clog2(LINE_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BYTES - 1);
    localparam logic [DAC_BITS-1:0] DAC_MASK = '1;

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;

    // line state
    logic [CNT_W-1:0]   count_reg, count_next;
    phase_t             phase_reg, phase_next;
    kind_t              kind_reg, kind_next;
    logic [VALUE_W-1:0] accum_a_reg, accum_a_next;
    logic [VALUE_W-1:0] accum_b_reg, accum_b_next;
    logic               seen_a_reg, seen_a_next;
    logic               seen_b_reg, seen_b_next;
    logic [VALUE_W-1:0] cur_a_reg, cur_a_next;
    logic [VALUE_W-1:0] cur_b_reg, cur_b_next;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    logic                  echo_valid_reg, echo_valid_next;
    logic [7:0]            echo_char_reg, echo_char_next;
    logic                  line_done_reg, line_done_next;
    status_t               status_reg, status_next;
    logic [DAC_WORD_W-1:0] dac_word_reg, dac_word_next;

    logic                  advance;
    logic                  fire;
    logic                  line_end;
    logic                  printable;
    logic                  digit;
    logic [3:0]            digit_val;
    logic [2*DAC_BITS-1:0] dac_full;

    // output register drains or is empty: the input stage may move on
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // parse one character against the line state
    always_comb
    begin
        line_end  = (count_reg == CNT_FULL) || (s1_char_reg == CH_CR) ||
                    (s1_char_reg == CH_LF);
        printable = s1_char_reg >= CH_SPACE;
        digit     = s1_char_reg inside {[CH_ZERO:CH_NINE]};
        digit_val = 4'(s1_char_reg - CH_ZERO);

        count_next   = count_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        accum_a_next = accum_a_reg;
        accum_b_next = accum_b_reg;
        seen_a_next  = seen_a_reg;
        seen_b_next  = seen_b_reg;
        cur_a_next   = cur_a_reg;
        cur_b_next   = cur_b_reg;

        echo_valid_next = 1'b0;
        echo_char_next  = '0;
        line_done_next  = 1'b0;
        status_next     = ST_COLLECT;
        dac_full        = '0;

        if (fire)
        begin
            if (line_end)
            begin
                line_done_next = 1'b1;
                case (kind_reg)
                    KIND_SET:
                    begin
                        cur_a_next = accum_a_reg;
                        if (seen_a_reg)
                        begin
                            cur_b_next = accum_b_reg;
                        end
                        if (seen_a_reg && seen_b_reg)
                        begin
                            status_next = ST_DAC;
                            dac_full    = {accum_a_reg[DAC_BITS-1:0] & DAC_MASK,
                                           accum_b_reg[DAC_BITS-1:0] & DAC_MASK};
                        end
                        else
                        begin
                            status_next = ST_FMT_ERR;
                        end
                    end
                    KIND_STORE: status_next = ST_STORE;
                    default:    status_next = ST_UNKNOWN;
                endcase
                count_next   = '0;
                phase_next   = PH_CMD;
                kind_next    = KIND_NONE;
                accum_a_next = '0;
                accum_b_next = '0;
                seen_a_next  = 1'b0;
                seen_b_next  = 1'b0;
            end
            else if (printable)
            begin
                echo_valid_next = 1'b1;
                echo_char_next  = s1_char_reg;
                count_next      = count_reg + CNT_W'(1);
                case (phase_reg)
                    PH_CMD:
                    begin
                        if (s1_char_reg == CH_CMD_SET)
                        begin
                            kind_next  = KIND_SET;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            kind_next  = (s1_char_reg == CH_CMD_STORE) ? KIND_STORE
                                                                       : KIND_OTHER;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_SKIP: phase_next = PH_A;
                    PH_A:
                    begin
                        if (digit)
                        begin
                            accum_a_next = add_digit(accum_a_reg, digit_val);
                            seen_a_next  = 1'b1;
                        end
                        else
                        begin
                            phase_next = seen_a_reg ? PH_B : PH_DONE;
                        end
                    end
                    PH_B:
                    begin
                        if (digit)
                        begin
                            accum_b_next = add_digit(accum_b_reg, digit_val);
                            seen_b_next  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
        dac_word_next = DAC_WORD_W'(dac_full);

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= PH_CMD;
            kind_reg      <= KIND_NONE;
            accum_a_reg   <= '0;
            accum_b_reg   <= '0;
            seen_a_reg    <= 1'b0;
            seen_b_reg    <= 1'b0;
            cur_a_reg     <= '0;
            cur_b_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            accum_a_reg   <= accum_a_next;
            accum_b_reg   <= accum_b_next;
            seen_a_reg    <= seen_a_next;
            seen_b_reg    <= seen_b_next;
            cur_a_reg     <= cur_a_next;
            cur_b_reg     <= cur_b_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= rx_char;
        end
        if (fire)
        begin
            echo_valid_reg <= echo_valid_next;
            echo_char_reg  <= echo_char_next;
            line_done_reg  <= line_done_next;
            status_reg     <= status_next;
            dac_word_reg   <= dac_word_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign echo_valid = echo_valid_reg;
    assign echo_char  = echo_char_reg;
    assign line_done  = line_done_reg;
    assign status     = status_reg;
    assign value_a    = cur_a_reg;
    assign value_b    = cur_b_reg;
    assign dac_word   = dac_word_reg;

    // a beat never both echoes and ends the line
    a_echo_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(echo_valid_reg && line_done_reg))
        else $error("echo and line end in one beat");

    // status only reported on a line end
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (line_done_reg == (status_reg != ST_COLLECT)))
        else $error("status without line end");

    // dac word is zero unless the set command succeeded
    a_dac_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_DAC)) |-> (dac_word_reg == '0))
        else $error("dac word outside successful set");

    // a line end restarts the line
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && line_end) |=> ((count_reg == '0) && (phase_reg == PH_CMD) &&
                                (kind_reg == KIND_NONE)))
        else $error("line state not cleared");

    // a stalled output holds the input stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_char_reg)))
        else $error("input stage lost under stall");

endmodule

// ----- test/sdcp_reply_checker.sv -----
`timescale 1ns / 100ps
// Reply checker for the serial DAC command parser: watches both channels,
// predicts every reply beat from the accepted characters and compares.
// Depends on sdcp_pkg.
module sdcp_reply_checker #(
    parameter int LINE_BYTES = sdcp_pkg::LINE_BYTES_DEF,
    parameter int DAC_BITS   = sdcp_pkg::DAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       rx_char,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             echo_valid,
    input  logic [7:0]                       echo_char,
    input  logic                             line_done,
    input  logic [2:0]                       status,
    input  logic [sdcp_pkg::VALUE_W-1:0]     value_a,
    input  logic [sdcp_pkg::VALUE_W-1:0]     value_b,
    input  logic [sdcp_pkg::DAC_WORD_W-1:0]  dac_word,
    output int                               in_flight,
    output int                               failures
);
    import sdcp_pkg::*;

    typedef struct packed {
        logic                   echo_valid;
        logic [7:0]             echo_char;
        logic                   line_done;
        status_t                status;
        logic [VALUE_W-1:0]     value_a;
        logic [VALUE_W-1:0]     value_b;
        logic [DAC_WORD_W-1:0]  dac_word;
    } dac_reply_t;

    dac_reply_t expected_replies[$];

    // shadow of the parser's line state
    int                 line_len;
    phase_t             phase;
    kind_t              cmd;
    logic [VALUE_W-1:0] acc_a, acc_b, chan_a, chan_b;
    logic               got_a, got_b;

    int mismatch_count = 0;
    int reply_no = 0;

    assign failures = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] reply %0d: %s", $realtime, reply_no, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic logic [VALUE_W-1:0] times_ten_plus(input logic [VALUE_W-1:0] v,
                                                          input logic [7:0] c);
        logic [31:0] wide;
        wide = 32'(v) * 32'd10 + 32'(c - CH_ZERO);
        return wide[VALUE_W-1:0];
    endfunction

    function automatic void clear_line();
        line_len = 0;
        phase    = PH_CMD;
        cmd      = KIND_NONE;
        acc_a    = '0;
        acc_b    = '0;
        got_a    = 1'b0;
        got_b    = 1'b0;
    endfunction

    function automatic dac_reply_t predict_reply(input logic [7:0] c);
        dac_reply_t r;
        logic       digit;
        logic [31:0] mask;
        logic [31:0] word;
        r     = '0;
        r.status = ST_COLLECT;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        mask  = (32'd1 << DAC_BITS) - 32'd1;
        if (line_len >= LINE_BYTES - 1 || c == CH_CR || c == CH_LF) begin
            // line ends here; a full line drops the character
            r.line_done = 1'b1;
            if (cmd == KIND_SET) begin
                chan_a = acc_a;
                if (got_a)
                    chan_b = acc_b;
                if (got_a && got_b) begin
                    word       = ((32'(chan_a) & mask) << DAC_BITS) | (32'(chan_b) & mask);
                    r.status   = ST_DAC;
                    r.dac_word = word[DAC_WORD_W-1:0];
                end
                else
                    r.status = ST_FMT_ERR;
            end
            else if (cmd == KIND_STORE)
                r.status = ST_STORE;
            else
                r.status = ST_UNKNOWN;
            clear_line();
        end
        else if (c >= CH_SPACE) begin
            r.echo_valid = 1'b1;
            r.echo_char  = c;
            case (phase)
                PH_CMD:
                begin
                    if (c == CH_CMD_SET) begin
                        cmd   = KIND_SET;
                        phase = PH_SKIP;
                    end
                    else begin
                        cmd   = (c == CH_CMD_STORE) ? KIND_STORE : KIND_OTHER;
                        phase = PH_DONE;
                    end
                end
                PH_SKIP:
                    phase = PH_A;
                PH_A:
                begin
                    if (digit) begin
                        acc_a = times_ten_plus(acc_a, c);
                        got_a = 1'b1;
                    end
                    else
                        phase = got_a ? PH_B : PH_DONE;
                end
                PH_B:
                begin
                    if (digit) begin
                        acc_b = times_ten_plus(acc_b, c);
                        got_b = 1'b1;
                    end
                    else
                        phase = PH_DONE;
                end
                default:
                    ;
            endcase
            line_len++;
        end
        r.value_a = chan_a;
        r.value_b = chan_b;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dac_reply_t want;
        if (!rst_n) begin
            clear_line();
            chan_a = '0;
            chan_b = '0;
            expected_replies.delete();
            in_flight <= 0;
        end
        else begin
            if (in_valid && in_ready)
                expected_replies.push_back(predict_reply(rx_char));
            if (out_valid && out_ready) begin
                reply_no++;
                if (expected_replies.size() == 0)
                    report_mismatch("reply beat with nothing expected");
                else begin
                    want = expected_replies.pop_front();
                    check_field("echo_valid", 32'(echo_valid), 32'(want.echo_valid));
                    check_field("echo_char", 32'(echo_char), 32'(want.echo_char));
                    check_field("line_done", 32'(line_done), 32'(want.line_done));
                    check_field("status", 32'(status), 32'(want.status));
                    check_field("value_a", 32'(value_a), 32'(want.value_a));
                    check_field("value_b", 32'(value_b), 32'(want.value_b));
                    check_field("dac_word", 32'(dac_word), 32'(want.dac_word));
                end
            end
            in_flight <= expected_replies.size();
        end
    end

endmodule

// ----- test/serial_dac_command_parser_test.sv -----
`timescale 1ns / 100ps
// Top of the serial DAC command parser test: clock, reset, character
// stimulus, receiver stalls, watchdog and verdict. Depends on sdcp_pkg,
// serial_dac_command_parser and sdcp_reply_checker.
module serial_dac_command_parser_test;
    import sdcp_pkg::*;

    localparam int LINE_BYTES   = LINE_BYTES_DEF;
    localparam int DAC_BITS     = DAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 1400;  // characters that the parser acts on
    localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES = 8;     // pipeline is two deep; a few spare

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_char   = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   echo_valid;
    logic [7:0]             echo_char;
    logic                   line_done;
    logic [2:0]             status;
    logic [VALUE_W-1:0]     value_a;
    logic [VALUE_W-1:0]     value_b;
    logic [DAC_WORD_W-1:0]  dac_word;

    int in_flight;
    int failures;

    // sender burst bookkeeping and the count of characters that do something
    int burst_left = 0;
    int counted    = 0;
    int idle_cycles = 0;

    // receiver stall pattern: a mode held for a random stretch of cycles
    int ready_mode = 0;
    int ready_hold = 0;

    logic [7:0] line_q[$];

    always #2 clk = ~clk;

    serial_dac_command_parser #(
        .LINE_BYTES (LINE_BYTES),
        .DAC_BITS   (DAC_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_char    (rx_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .echo_valid (echo_valid),
        .echo_char  (echo_char),
        .line_done  (line_done),
        .status     (status),
        .value_a    (value_a),
        .value_b    (value_b),
        .dac_word   (dac_word)
    );

    sdcp_reply_checker #(
        .LINE_BYTES (LINE_BYTES),
        .DAC_BITS   (DAC_BITS)
    ) reply_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_char    (rx_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .echo_valid (echo_valid),
        .echo_char  (echo_char),
        .line_done  (line_done),
        .status     (status),
        .value_a    (value_a),
        .value_b    (value_b),
        .dac_word   (dac_word),
        .in_flight  (in_flight),
        .failures   (failures)
    );

    // Receiver: every so often pick a new stall mode. Mode 0 never stalls,
    // the others stall lightly, half the time, or most of the time.
    always @(posedge clk)
    begin
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(16, 96);
        end
        else
            ready_hold <= ready_hold - 1;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: a run of cycles with no beat on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("serial_dac_command_parser test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Printable byte, 0x20 up to 0xFF; the parser echoes all of these.
    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(32, 255));
    endfunction

    // Digit count for a decimal field: mostly short, some empty, some long
    // enough to wrap the 16-bit accumulator.
    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        else if (r <= 2)
            return $urandom_range(6, 7);
        else
            return $urandom_range(1, 4);
    endfunction

    task automatic push_digits(input int n);
        repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_text(input int n);
        repeat (n) line_q.push_back(rand_printable());
    endtask

    // Send one character beat. Called at a rising edge; returns at the edge
    // where the beat was taken. The sender works in bursts: between bursts
    // valid drops for a random gap. A zero gap keeps valid high so it is
    // never lowered and raised in the same step.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_char  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        if (c >= CH_SPACE || c == CH_CR || c == CH_LF)
            counted++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    initial
    begin
        // single reset at the start
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        send_text("a 1,2x");            // set command, text after B ignored
        send_char(CH_CR);
        send_char(CH_CMD_STORE);        // store request, LF terminated
        send_char(CH_LF);
        send_char(CH_CR);               // empty line is unknown
        send_char(8'h00);               // ignored control byte
        send_char("q");                 // unknown command
        send_char(8'hFF);               // top byte is printable and echoed
        send_char(CH_CR);
        send_text("a ");                // no A digits: format error
        send_char(CH_CR);
        send_text("a 9");               // line ends right after A
        send_char(CH_LF);
        send_text("a 7,");              // separator but no B digits
        send_char(CH_CR);

        counted = 0;

        // random lines, mostly well formed set commands
        while (counted < RANDOM_ITEMS)
        begin : one_line
            int         pick;
            logic [7:0] sep;
            bit         full_line;
            line_q.delete();
            full_line = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                line_q.push_back(CH_CMD_SET);
                line_q.push_back(rand_printable());   // skipped character
                push_digits(digit_count());
                if ($urandom_range(0, 9) != 0) begin
                    do
                        sep = rand_printable();
                    while (sep >= CH_ZERO && sep <= CH_NINE);
                    line_q.push_back(sep);
                    push_digits(digit_count());
                    if ($urandom_range(0, 3) == 0)
                        push_text($urandom_range(1, 6));
                end
            end
            else if (pick < 65) begin
                line_q.push_back(CH_CMD_STORE);
                push_text($urandom_range(0, 5));
            end
            else if (pick < 75)
                push_text($urandom_range(1, 8));
            else if (pick < 80)
                ;                                   // empty line
            else if (pick < 86) begin
                // overlong line: fills the buffer, the next byte of any kind
                // ends it and is dropped
                full_line = 1'b1;
                if ($urandom_range(0, 1)) begin
                    line_q.push_back(CH_CMD_SET);
                    line_q.push_back(CH_SPACE);
                    push_digits(digit_count());
                    line_q.push_back(",");
                    push_digits(digit_count());
                end
                while (line_q.size() < LINE_BYTES - 1)
                    line_q.push_back(rand_printable());
                line_q.push_back(8'($urandom_range(0, 255)));
            end
            else
                repeat ($urandom_range(1, 10))
                    line_q.push_back(8'($urandom_range(0, 255)));

            if (!full_line) begin
                // an ignored control byte somewhere in the line now and then
                if ($urandom_range(0, 4) == 0) begin
                    do
                        sep = 8'($urandom_range(0, 31));
                    while (sep == CH_CR || sep == CH_LF);
                    line_q.insert($urandom_range(0, line_q.size()), sep);
                end
                line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end

            foreach (line_q[i])
                send_char(line_q[i]);
        end

        in_valid <= 1'b0;

        // in_flight is a registered copy of the expected queue size; wait for
        // every expected reply, then let the pipeline settle
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("serial_dac_command_parser test passed");
        else
            $display("serial_dac_command_parser test failed");
        $finish;
    end

endmodule
